@@ design/dbfb_pkg.sv @@
// shared types, codes and frame encoding for the dshot bit-plane frame builder
`timescale 1ns / 1ps

package dbfb_pkg;

    // number of channels that set and clear commands may address
    localparam int CHANNELS = 8;
    localparam int PLANES   = 16;
    localparam int PIDX_W   = 4;

    localparam logic [PIDX_W-1:0] PLANE_LAST = PIDX_W'(PLANES - 1);

    // command codes
    localparam logic [1:0] FN_SET   = 2'd0;
    localparam logic [1:0] FN_CLEAR = 2'd1;
    localparam logic [1:0] FN_SEND  = 2'd2;

    // plane indices touched by the post-send repair
    localparam int TEL_PLANE = 11;
    localparam int CRC0_PLANE = 15;

    // commands from controller to datapath
    typedef struct packed {
        logic               do_set;
        logic               do_clear;
        logic               load;
        logic [PIDX_W-1:0]  idx;
        logic               last;
        logic               fix;
    } t_dp_cmd;

    // 16-bit frame: throttle, telemetry bit, xor-nibble crc
    function automatic logic [15:0] build_frame(input logic [10:0] thr, input logic tel);
        logic [15:0] enc;
        logic [7:0]  crc;
        enc = {thr, tel, 4'h0};
        crc = enc[7:0] ^ enc[15:8];
        crc = crc ^ {4'h0, crc[7:4]};
        return {enc[15:4], crc[3:0]};
    endfunction

endpackage

@@ design/dbfb_if.sv @@
// handshake channels for commands and plane results
`timescale 1ns / 1ps

interface dbfb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [10:0] throttle;
    logic        telemetry_req;

    modport source (output valid, func, channel, throttle, telemetry_req, input ready);
    modport sink   (input valid, func, channel, throttle, telemetry_req, output ready);
endinterface

interface dbfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plane_byte;
    logic [3:0] plane_index;
    logic [7:0] active_mask;
    logic       last;

    modport source (output valid, plane_byte, plane_index, active_mask, last, input ready);
    modport sink   (input valid, plane_byte, plane_index, active_mask, last, output ready);
endinterface

@@ design/dbfb_ctrl.sv @@
// command decode and plane emission sequencer
`timescale 1ns / 1ps

module dbfb_ctrl
    import dbfb_pkg::*;
#(
    parameter int CHANNELS = dbfb_pkg::CHANNELS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_channel,
    input  logic        i_out_free,
    output logic        o_in_ready,
    output t_dp_cmd     o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SEND
    } t_state;

    t_state             r_state;
    logic [PIDX_W-1:0]  r_idx;
    logic               w_accept;
    logic               w_ch_ok;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ch_ok    = ({1'b0, i_channel} < 4'(CHANNELS));

    // command decode and plane load/repair strobes
    always_comb begin
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        o_cmd.last     = (r_idx == PLANE_LAST);
        if (w_accept && w_ch_ok) begin
            unique case (i_func)
                FN_SET:   o_cmd.do_set   = 1'b1;
                FN_CLEAR: o_cmd.do_clear = 1'b1;
                default:  ;
            endcase
        end
        if (r_state == S_SEND && i_out_free) begin
            o_cmd.load = 1'b1;
            o_cmd.fix  = (r_idx == PLANE_LAST);
        end
    end

    // state and plane counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_accept && i_func == FN_SEND) begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (i_out_free) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == PLANE_LAST) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fix_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fix |-> (o_cmd.load && o_cmd.idx == PLANE_LAST))
        else $error("plane repair outside the last plane load");
    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FN_SEND) |=> (r_state == S_SEND && r_idx == '0))
        else $error("send transfer did not start emission at plane 0");
    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && r_idx != PLANE_LAST) |=> (r_idx == $past(r_idx) + 1'b1))
        else $error("plane counter skipped");
    a_no_update_during_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((o_cmd.do_set || o_cmd.do_clear) && r_state == S_SEND))
        else $error("plane update during emission");
`endif

endmodule

@@ design/dbfb_dp.sv @@
// bit-plane storage, active mask and output register
`timescale 1ns / 1ps

module dbfb_dp
    import dbfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [2:0]  i_channel,
    input  logic [10:0] i_throttle,
    input  logic        i_telemetry_req,
    input  logic        i_out_ready,
    output logic        o_out_free,
    output logic        o_out_valid,
    output logic [7:0]  o_plane_byte,
    output logic [3:0]  o_plane_index,
    output logic [7:0]  o_active_mask,
    output logic        o_last
);

    logic [7:0]         r_planes [PLANES];
    logic [7:0]         r_active;
    logic               r_out_valid;
    logic [7:0]         r_plane_byte;
    logic [PIDX_W-1:0]  r_plane_index;
    logic [7:0]         r_active_mask;
    logic               r_last;
    logic [15:0]        w_frame;

    assign w_frame    = build_frame(i_throttle, i_telemetry_req);
    assign o_out_free = !r_out_valid || i_out_ready;

    // plane store and active mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANES; i++) begin
                r_planes[i] <= '0;
            end
            r_active <= '0;
        end else begin
            if (i_cmd.do_set) begin
                r_active[i_channel] <= 1'b1;
                for (int i = 0; i < PLANES; i++) begin
                    r_planes[i][i_channel] <= ~w_frame[PLANES-1-i];
                end
            end else if (i_cmd.do_clear) begin
                r_active[i_channel] <= 1'b0;
                for (int i = 0; i < PLANES; i++) begin
                    r_planes[i][i_channel] <= 1'b0;
                end
            end else if (i_cmd.fix) begin
                // drop telemetry bit and flip the crc low bit to match
                r_planes[CRC0_PLANE] <= ~(r_planes[CRC0_PLANE] ^ r_planes[TEL_PLANE]);
                r_planes[TEL_PLANE]  <= 8'hFF;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_plane_byte  <= r_planes[i_cmd.idx];
            r_plane_index <= i_cmd.idx;
            r_active_mask <= r_active;
            r_last        <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_plane_byte  = r_plane_byte;
    assign o_plane_index = r_plane_index;
    assign o_active_mask = r_active_mask;
    assign o_last        = r_last;

endmodule

@@ design/dshot_bitplane_frame_builder.sv @@
// top level of the dshot bit-plane frame builder
`timescale 1ns / 1ps

// Keeps up to eight 16-bit dshot frames (11-bit throttle, telemetry bit,
// xor-nibble crc) stored as 16 inverted bit planes, one byte per frame bit
// and one bit per channel. Set and clear commands produce no output. A send
// command is accepted and then emits the 16 planes, most significant frame
// bit first, through the plane counter and the single output register, one
// per cycle while the sink is ready; output stalls hold the emission. No
// new command is taken while planes are being emitted. After the last plane
// all telemetry bits are cleared and the crc low bit is repaired.
module dshot_bitplane_frame_builder
    import dbfb_pkg::*;
#(
    parameter int CHANNELS = dbfb_pkg::CHANNELS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbfb_in_if.sink     i_cmd,
    dbfb_out_if.source  o_plane
);

    t_dp_cmd    w_cmd;
    logic       w_out_free;
    logic       w_in_ready;

    assign i_cmd.ready = w_in_ready;

    // command sequencer
    dbfb_ctrl #(
        .CHANNELS   (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_func     (i_cmd.func),
        .i_channel  (i_cmd.channel),
        .i_out_free (w_out_free),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // plane storage and output
    dbfb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_channel       (i_cmd.channel),
        .i_throttle      (i_cmd.throttle),
        .i_telemetry_req (i_cmd.telemetry_req),
        .i_out_ready     (o_plane.ready),
        .o_out_free      (w_out_free),
        .o_out_valid     (o_plane.valid),
        .o_plane_byte    (o_plane.plane_byte),
        .o_plane_index   (o_plane.plane_index),
        .o_active_mask   (o_plane.active_mask),
        .o_last          (o_plane.last)
    );

endmodule
